[hdl/crb_pkg.sv]
// Shared types and constants for the camera rotation basis core.
// Depends on nothing; every other file imports it.
`default_nettype none

package crb_pkg;

	// Input word: position, Euler angles (degrees) and quaternion, all signed fixed point
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] angle_x;
		logic signed [31:0] angle_y;
		logic signed [31:0] angle_z;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic signed [31:0] quat_w;
	} in_word_t;

	// Output word: eye, target and up vectors
	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
	} out_word_t;

	// Fields that bypass the angle and CORDIC stages
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic signed [31:0] quat_w;
	} side_t;

	// Register indexes
	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_FACTOR_X = 3'd1;
	localparam logic [2:0] REG_FACTOR_Y = 3'd2;
	localparam logic [2:0] REG_FACTOR_Z = 3'd3;
	localparam logic [2:0] REG_OFFSET_X = 3'd4;
	localparam logic [2:0] REG_OFFSET_Y = 3'd5;
	localparam logic [2:0] REG_OFFSET_Z = 3'd6;

	// Pipeline depths
	localparam int ANGLE_STAGES = 6;
	localparam int CORDIC_STEPS = 30;
	localparam int BASIS_STAGES = 3;

	// CORDIC constants in Q2.30
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam int DEG_TO_RAD = 18740330;

	// Modulo-360 reduction of the integer degree count, one byte at a time
	localparam int MOD_SW   = 19;       // width of the biased byte sum
	localparam int MOD_QW   = 10;       // width of the quotient
	localparam int MOD_BIAS = 33120;    // 92 * 360, keeps the sum positive
	localparam int MOD_M    = 1491309;  // ceil(2^29 / 360)
	localparam int MOD_K    = 29;
	localparam int MOD_RES7 = 256;      // 2^56 mod 360, for the signed top byte

	// 2^(8j) mod 360 for the unsigned low bytes
	function automatic int mod_res(input int j);
		int r;
		case (j)
			0: r = 1;
			1: r = 256;
			2: r = 16;
			3: r = 136;
			4: r = 256;
			5: r = 16;
			6: r = 136;
			default: r = 0;
		endcase
		return r;
	endfunction

	// atan(2^-i) in Q2.30
	function automatic logic signed [31:0] atan_q30(input int i);
		logic signed [31:0] r;
		case (i)
			0: r = 32'sd843314857;
			1: r = 32'sd497837829;
			2: r = 32'sd263043837;
			3: r = 32'sd133525159;
			4: r = 32'sd67021687;
			5: r = 32'sd33543516;
			6: r = 32'sd16775851;
			7: r = 32'sd8388437;
			8: r = 32'sd4194283;
			9: r = 32'sd2097149;
			default: r = 32'sd1 <<< (30 - i);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/camera_rotation_basis_core.sv]
// Camera rotation basis: Euler or quaternion to rotation matrix, then look-at vectors.
// Top level; instantiates crb_angle, crb_cordic and crb_basis; uses crb_pkg.
//
// Use:
//   Input words (in_valid / in_stall / in_word) carry position, three Euler angles
//   in degrees and a quaternion. Each yields exactly one output word
//   (out_valid / out_stall / out_word): eye, target and up vectors.
//   Registers are written through cfg_wen / cfg_idx / cfg_wdata while idle.
// Pipeline: 6 angle-reduction stages, one CORDIC stage per each of 30 iterations,
//   3 matrix/output stages.
// Throughput: one word per cycle while no stall holds the pipeline; every stage
//   is a register, the pipeline advances as one.
// Stall: when out_valid is high and out_stall is high the whole pipeline holds,
//   and in_stall goes high in the same cycle; nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and loads register defaults (Euler
//   mode, unit scale factors, zero offsets); no clearing pass is needed.
`default_nettype none

module camera_rotation_basis_core import crb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_word_t    in_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_word_t        out_word,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_wdata
);

	localparam int LAT      = ANGLE_STAGES + CORDIC_STEPS + BASIS_STAGES;
	localparam int SIDE_LAT = ANGLE_STAGES + CORDIC_STEPS;
	localparam int CW       = FRAC_BITS + 3;

	logic               mode_q;
	logic signed [31:0] factor_q [3];
	logic signed [31:0] offset_q [3];
	logic [LAT-1:0]     vld_q;
	side_t              side_q [SIDE_LAT];
	logic               adv;

	logic signed [31:0]   angle_v [3];
	logic signed [31:0]   z_v [3];
	logic                 neg_v [3];
	logic signed [CW-1:0] cos_v [3];
	logic signed [CW-1:0] sin_v [3];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				factor_q[k] <= 32'sd1 <<< FRAC_BITS;
				offset_q[k] <= '0;
			end
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_MODE:     mode_q      <= cfg_wdata[0];
				REG_FACTOR_X: factor_q[0] <= cfg_wdata;
				REG_FACTOR_Y: factor_q[1] <= cfg_wdata;
				REG_FACTOR_Z: factor_q[2] <= cfg_wdata;
				REG_OFFSET_X: offset_q[0] <= cfg_wdata;
				REG_OFFSET_Y: offset_q[1] <= cfg_wdata;
				REG_OFFSET_Z: offset_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Hold everything while a finished word waits
	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[LAT-1];

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Delay position and quaternion to meet the CORDIC results
	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= '{pos_x: in_word.pos_x, pos_y: in_word.pos_y,
				pos_z: in_word.pos_z, quat_x: in_word.quat_x, quat_y: in_word.quat_y,
				quat_z: in_word.quat_z, quat_w: in_word.quat_w};
			for (int i = 1; i < SIDE_LAT; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	assign angle_v[0] = in_word.angle_x;
	assign angle_v[1] = in_word.angle_y;
	assign angle_v[2] = in_word.angle_z;

	for (genvar k = 0; k < 3; k++) begin : g_axis
		crb_angle #(.FRAC_BITS(FRAC_BITS)) u_angle (
			.clk     (clk),
			.en      (adv),
			.angle   (angle_v[k]),
			.factor  (factor_q[k]),
			.offset  (offset_q[k]),
			.z       (z_v[k]),
			.neg_cos (neg_v[k])
		);

		crb_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
			.clk    (clk),
			.en     (adv),
			.z_in   (z_v[k]),
			.neg_in (neg_v[k]),
			.cos_v  (cos_v[k]),
			.sin_v  (sin_v[k])
		);
	end

	crb_basis #(.FRAC_BITS(FRAC_BITS)) u_basis (
		.clk    (clk),
		.en     (adv),
		.mode   (mode_q),
		.cos_v  (cos_v),
		.sin_v  (sin_v),
		.side   (side_q[SIDE_LAT-1]),
		.result (out_word)
	);

endmodule

`default_nettype wire

[hdl/crb_angle.sv]
// One Euler axis: scale, offset, reduce modulo 360 degrees, fold, convert to Q2.30 radians.
// Six register stages; uses crb_pkg.
`default_nettype none

module crb_angle import crb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [31:0] angle,
	input  wire logic signed [31:0] factor,
	input  wire logic signed [31:0] offset,
	output logic signed [31:0]      z,
	output logic                    neg_cos
);

	localparam int DW = FRAC_BITS + 10;
	localparam logic signed [DW-1:0] FULL_D    = DW'(360) << FRAC_BITS;
	localparam logic signed [DW-1:0] HALF_D    = DW'(180) << FRAC_BITS;
	localparam logic signed [DW-1:0] QUARTER_D = DW'(90) << FRAC_BITS;
	localparam logic signed [DW+25:0] D2R = (DW+26)'(DEG_TO_RAD);

	logic signed [63:0]     prod_s1;
	logic signed [63:0]     e_s2;
	logic [MOD_SW-1:0]      sum_s3;
	logic [FRAC_BITS-1:0]   frac_s3;
	logic [MOD_SW-1:0]      sum_s4;
	logic [MOD_QW-1:0]      quo_s4;
	logic [FRAC_BITS-1:0]   frac_s4;
	logic signed [DW-1:0]   deg_s5;
	logic                   neg_s5;
	logic signed [31:0]     z_s6;
	logic                   neg_s6;

	logic signed [63:0]     n_int;
	int                     acc;
	logic [MOD_SW+20:0]     mq;
	logic [MOD_SW-1:0]      rem_full;
	logic signed [DW-1:0]   d0;
	logic signed [DW-1:0]   d1;
	logic signed [DW-1:0]   d2;
	logic                   neg_d;
	logic signed [DW+25:0]  zp;

	// Byte-wise residue sum of the integer degree count
	always_comb begin
		n_int = e_s2 >>> FRAC_BITS;
		acc = MOD_BIAS;
		for (int j = 0; j < 7; j++) begin
			acc = acc + int'(n_int[8*j +: 8]) * mod_res(j);
		end
		acc = acc + int'($signed(n_int[63:56])) * MOD_RES7;
	end

	// Quotient by reciprocal multiply
	assign mq = (MOD_SW+21)'(sum_s3) * (MOD_SW+21)'(MOD_M);

	// Remainder, place in [-180,180), fold beyond a quarter turn
	always_comb begin
		rem_full = sum_s4 - MOD_SW'(32'(quo_s4) * 360);
		d0 = $signed({1'b0, rem_full[8:0], frac_s4});
		d1 = (d0 >= HALF_D) ? d0 - FULL_D : d0;
		neg_d = 1'b0;
		d2 = d1;
		if (d1 > QUARTER_D) begin
			d2 = HALF_D - d1;
			neg_d = 1'b1;
		end else if (d1 < -QUARTER_D) begin
			d2 = -HALF_D - d1;
			neg_d = 1'b1;
		end
	end

	// Degrees to Q2.30 radians
	assign zp = deg_s5 * D2R;

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(angle) * 64'(factor);
			e_s2    <= (prod_s1 >>> FRAC_BITS) + 64'(offset);
			sum_s3  <= acc[MOD_SW-1:0];
			frac_s3 <= e_s2[FRAC_BITS-1:0];
			sum_s4  <= sum_s3;
			quo_s4  <= mq[MOD_K +: MOD_QW];
			frac_s4 <= frac_s3;
			deg_s5  <= d2;
			neg_s5  <= neg_d;
			z_s6    <= 32'(zp >>> FRAC_BITS);
			neg_s6  <= neg_s5;
		end
	end

	assign z       = z_s6;
	assign neg_cos = neg_s6;

endmodule

`default_nettype wire

[hdl/crb_cordic.sv]
// Rotation-mode CORDIC, one iteration per register stage, Q2.30 internally.
// Delivers cosine and sine floored to the output fraction width; uses crb_pkg.
`default_nettype none

module crb_cordic import crb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [31:0]       z_in,
	input  wire logic                     neg_in,
	output logic signed [FRAC_BITS+2:0]   cos_v,
	output logic signed [FRAC_BITS+2:0]   sin_v
);

	localparam int CW = FRAC_BITS + 3;

	logic signed [31:0] x_s [CORDIC_STEPS];
	logic signed [31:0] y_s [CORDIC_STEPS];
	logic signed [31:0] z_s [CORDIC_STEPS];
	logic               neg_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [31:0] xi;
		logic signed [31:0] yi;
		logic signed [31:0] zi;
		logic               ni;

		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = z_in;
			assign ni = neg_in;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ni = neg_s[i-1];
		end

		// Rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - atan_q30(i);
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + atan_q30(i);
				end
				neg_s[i] <= ni;
			end
		end
	end

	logic signed [CW-1:0] cos_raw;

	// Floor to output fraction and undo the fold
	assign cos_raw = CW'(x_s[CORDIC_STEPS-1] >>> (30 - FRAC_BITS));
	assign cos_v   = neg_s[CORDIC_STEPS-1] ? -cos_raw : cos_raw;
	assign sin_v   = CW'(y_s[CORDIC_STEPS-1] >>> (30 - FRAC_BITS));

endmodule

`default_nettype wire

[hdl/crb_basis.sv]
// Rotation matrix columns from Euler sine/cosine or from the quaternion,
// then eye, plus target and up with saturation. Three register stages; uses crb_pkg.
`default_nettype none

module crb_basis import crb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic                   mode,
	input  wire logic signed [FRAC_BITS+2:0] cos_v [3],
	input  wire logic signed [FRAC_BITS+2:0] sin_v [3],
	input  wire side_t                  side,
	output out_word_t                   result
);

	localparam int CW = FRAC_BITS + 3;
	localparam int PW = 64 - FRAC_BITS;
	localparam int RW = PW + 2;
	localparam logic signed [RW-1:0] ONE = RW'(1) << FRAC_BITS;

	// Floored fixed-point product of two trig values
	function automatic logic signed [CW-1:0] tmul(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		return CW'(p >>> FRAC_BITS);
	endfunction

	// Floored fixed-point product of two quaternion components
	function automatic logic signed [PW-1:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return PW'(p >>> FRAC_BITS);
	endfunction

	// Clamp to the 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [RW:0] v);
		logic signed [31:0] r;
		if (v > (RW+1)'(32'sh7fffffff)) r = 32'sh7fffffff;
		else if (v < (RW+1)'(32'sh80000000)) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// Stage 1 registers
	logic signed [CW-1:0] cx_s1, sx_s1, cy_s1, sy_s1, cz_s1, sz_s1;
	logic signed [CW-1:0] sysx_s1, sycx_s1, cysx_s1, cycx_s1;
	logic signed [PW-1:0] qxx_s1, qyy_s1, qzz_s1, qxy_s1, qwz_s1;
	logic signed [PW-1:0] qxz_s1, qwy_s1, qyz_s1, qwx_s1;
	logic signed [31:0]   pos_s1 [3];

	// Stage 2 registers
	logic signed [RW-1:0] rc1_s2 [3];
	logic signed [RW-1:0] rc2_s2 [3];
	logic signed [31:0]   pos_s2 [3];

	// Stage 3 register
	out_word_t result_s3;

	logic signed [RW-1:0] e_c1 [3];
	logic signed [RW-1:0] e_c2 [3];
	logic signed [RW-1:0] q_c1 [3];
	logic signed [RW-1:0] q_c2 [3];
	logic signed [2*CW:0] acc_r11;
	logic signed [2*CW:0] acc_r21;
	logic signed [2*CW-1:0] p_r01;
	logic signed [RW:0]   tgt [3];

	// Columns 1 and 2 of R for both modes, and the target from the stage 2 registers
	always_comb begin
		p_r01   = cx_s1 * sz_s1;
		acc_r11 = sysx_s1 * sz_s1 + cy_s1 * cz_s1;
		acc_r21 = cysx_s1 * sz_s1 - sy_s1 * cz_s1;
		e_c1[0] = RW'(p_r01 >>> FRAC_BITS);
		e_c1[1] = RW'(acc_r11 >>> FRAC_BITS);
		e_c1[2] = RW'(acc_r21 >>> FRAC_BITS);
		e_c2[0] = RW'(-sx_s1);
		e_c2[1] = RW'(sycx_s1);
		e_c2[2] = RW'(cycx_s1);
		q_c1[0] = (RW'(qxy_s1) + RW'(qwz_s1)) <<< 1;
		q_c1[1] = ONE - ((RW'(qzz_s1) + RW'(qxx_s1)) <<< 1);
		q_c1[2] = (RW'(qyz_s1) - RW'(qwx_s1)) <<< 1;
		q_c2[0] = (RW'(qxz_s1) - RW'(qwy_s1)) <<< 1;
		q_c2[1] = (RW'(qyz_s1) + RW'(qwx_s1)) <<< 1;
		q_c2[2] = ONE - ((RW'(qyy_s1) + RW'(qxx_s1)) <<< 1);
		for (int k = 0; k < 3; k++) begin
			tgt[k] = (RW+1)'(pos_s2[k]) - (RW+1)'(rc2_s2[k]);
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1   <= cos_v[0];
			sx_s1   <= sin_v[0];
			cy_s1   <= cos_v[1];
			sy_s1   <= sin_v[1];
			cz_s1   <= cos_v[2];
			sz_s1   <= sin_v[2];
			sysx_s1 <= tmul(sin_v[1], sin_v[0]);
			sycx_s1 <= tmul(sin_v[1], cos_v[0]);
			cysx_s1 <= tmul(cos_v[1], sin_v[0]);
			cycx_s1 <= tmul(cos_v[1], cos_v[0]);
			qxx_s1  <= qmul(side.quat_x, side.quat_x);
			qyy_s1  <= qmul(side.quat_y, side.quat_y);
			qzz_s1  <= qmul(side.quat_z, side.quat_z);
			qxy_s1  <= qmul(side.quat_x, side.quat_y);
			qwz_s1  <= qmul(side.quat_z, side.quat_w);
			qxz_s1  <= qmul(side.quat_z, side.quat_x);
			qwy_s1  <= qmul(side.quat_y, side.quat_w);
			qyz_s1  <= qmul(side.quat_y, side.quat_z);
			qwx_s1  <= qmul(side.quat_x, side.quat_w);
			pos_s1[0] <= side.pos_x;
			pos_s1[1] <= side.pos_y;
			pos_s1[2] <= side.pos_z;
			for (int k = 0; k < 3; k++) begin
				rc1_s2[k] <= mode ? q_c1[k] : e_c1[k];
				rc2_s2[k] <= mode ? q_c2[k] : e_c2[k];
				pos_s2[k] <= pos_s1[k];
			end
			result_s3.eye_x    <= pos_s2[0];
			result_s3.eye_y    <= pos_s2[1];
			result_s3.eye_z    <= pos_s2[2];
			result_s3.target_x <= sat32(tgt[0]);
			result_s3.target_y <= sat32(tgt[1]);
			result_s3.target_z <= sat32(tgt[2]);
			result_s3.up_x     <= sat32((RW+1)'(rc1_s2[0]));
			result_s3.up_y     <= sat32((RW+1)'(rc1_s2[1]));
			result_s3.up_z     <= sat32((RW+1)'(rc1_s2[2]));
		end
	end

	assign result = result_s3;

endmodule

`default_nettype wire

[tb/sv/tb_camera_rotation_basis_core.sv]
// Self-checking testbench for camera_rotation_basis_core: Euler and quaternion words
// are checked against a bit-exact fixed-point predictor of eye, target and up.
// Depends on crb_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_camera_rotation_basis_core;
	import crb_pkg::*;

	localparam int FRAC = 16;
	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 50;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam longint GAIN_Q30 = 652032874;
	localparam longint RAD_PER_DEG_Q30 = 18740330;

	typedef longint mat_t [3][3];

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_word;
	logic out_valid;
	logic out_stall;
	out_word_t out_word;
	logic cfg_wen;
	logic [2:0] cfg_idx;
	logic [31:0] cfg_wdata;

	// Shadow copy of the register file
	logic quat_mode;
	logic signed [31:0] scale_q [3];
	logic signed [31:0] shift_q [3];

	out_word_t basis_q [$];
	longint atan_tab [30];
	int cycle_cnt;
	int fail_cnt;
	int hold_cycles;
	bit quiet;

	camera_rotation_basis_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Sine and cosine of an angle in fixed-point degrees
	function automatic void deg_sincos(input longint deg, output longint c, output longint s);
		longint full, half, quarter, d, x, y, z, dx, dy;
		bit flip;
		full = longint'(360) << FRAC;
		half = longint'(180) << FRAC;
		quarter = longint'(90) << FRAC;
		flip = 1'b0;
		d = deg % full;
		if (d < 0) d += full;
		if (d >= half) d -= full;
		if (d > quarter) begin
			d = half - d;
			flip = 1'b1;
		end else if (d < -quarter) begin
			d = -half - d;
			flip = 1'b1;
		end
		z = (d * RAD_PER_DEG_Q30) >>> FRAC;
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end
		end
		c = x >>> (30 - FRAC);
		s = y >>> (30 - FRAC);
		if (flip) c = -c;
	endfunction

	function automatic void mat_mul(input mat_t a, input mat_t b, output mat_t r);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				r[i][j] = (a[i][0] * b[0][j] + a[i][1] * b[1][j] + a[i][2] * b[2][j]) >>> FRAC;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Expected eye, target and up for one input word
	function automatic out_word_t predict_basis(input in_word_t w);
		longint one, e, qx, qy, qz, qw;
		longint xx, yy, zz, xy, wz, xz, wy, yz, wx;
		longint c [3];
		longint s [3];
		longint ang [3];
		longint pos [3];
		mat_t rx, ry, rz, t, r;
		out_word_t o;
		one = longint'(1) << FRAC;
		ang[0] = w.angle_x;
		ang[1] = w.angle_y;
		ang[2] = w.angle_z;
		pos[0] = w.pos_x;
		pos[1] = w.pos_y;
		pos[2] = w.pos_z;
		if (quat_mode) begin
			qx = w.quat_x;
			qy = w.quat_y;
			qz = w.quat_z;
			qw = w.quat_w;
			xx = (qx * qx) >>> FRAC;
			yy = (qy * qy) >>> FRAC;
			zz = (qz * qz) >>> FRAC;
			xy = (qx * qy) >>> FRAC;
			wz = (qz * qw) >>> FRAC;
			xz = (qz * qx) >>> FRAC;
			wy = (qy * qw) >>> FRAC;
			yz = (qy * qz) >>> FRAC;
			wx = (qx * qw) >>> FRAC;
			r[0][1] = 2 * (xy + wz);
			r[0][2] = 2 * (xz - wy);
			r[1][1] = one - 2 * (zz + xx);
			r[1][2] = 2 * (yz + wx);
			r[2][1] = 2 * (yz - wx);
			r[2][2] = one - 2 * (yy + xx);
		end else begin
			for (int k = 0; k < 3; k++) begin
				e = ((ang[k] * longint'(scale_q[k])) >>> FRAC) + longint'(shift_q[k]);
				deg_sincos(e, c[k], s[k]);
			end
			rx = '{'{one, 0, 0}, '{0, c[1], s[1]}, '{0, -s[1], c[1]}};
			ry = '{'{c[0], 0, -s[0]}, '{0, one, 0}, '{s[0], 0, c[0]}};
			rz = '{'{c[2], s[2], 0}, '{-s[2], c[2], 0}, '{0, 0, one}};
			mat_mul(rx, ry, t);
			mat_mul(t, rz, r);
		end
		o.eye_x = w.pos_x;
		o.eye_y = w.pos_y;
		o.eye_z = w.pos_z;
		o.target_x = clamp32(pos[0] - r[0][2]);
		o.target_y = clamp32(pos[1] - r[1][2]);
		o.target_z = clamp32(pos[2] - r[2][2]);
		o.up_x = clamp32(r[0][1]);
		o.up_y = clamp32(r[1][1]);
		o.up_z = clamp32(r[2][1]);
		return o;
	endfunction

	// Random field: edges, small values or full range
	function automatic logic [31:0] pick32(input int small_max);
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return $urandom_range(0, 2 * small_max) - small_max;
		endcase
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		w.pos_x = pick32(100 << FRAC);
		w.pos_y = pick32(100 << FRAC);
		w.pos_z = pick32(100 << FRAC);
		w.angle_x = pick32(720 << FRAC);
		w.angle_y = pick32(720 << FRAC);
		w.angle_z = pick32(720 << FRAC);
		w.quat_x = pick32(2 << FRAC);
		w.quat_y = pick32(2 << FRAC);
		w.quat_z = pick32(2 << FRAC);
		w.quat_w = pick32(2 << FRAC);
		return w;
	endfunction

	function automatic in_word_t make_word(input logic [31:0] p, input logic [31:0] ax,
		input logic [31:0] ay, input logic [31:0] az, input logic [31:0] q);
		in_word_t w;
		w = '{p, p, ~p, ax, ay, az, q, ~q, q, 32'h10000};
		return w;
	endfunction

	// Offer one word, with a random gap ahead of it, and wait for acceptance
	task automatic send_word(input in_word_t w);
		while (!quiet && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		basis_q.push_back(predict_basis(w));
	endtask

	// Drop valid and wait until every expected word has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (basis_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		drain();
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_MODE: quat_mode = data[0];
			REG_FACTOR_X: scale_q[0] = data;
			REG_FACTOR_Y: scale_q[1] = data;
			REG_FACTOR_Z: scale_q[2] = data;
			REG_OFFSET_X: shift_q[0] = data;
			REG_OFFSET_Y: shift_q[1] = data;
			REG_OFFSET_Z: shift_q[2] = data;
			default: ;
		endcase
	endtask

	// Euler corner angles and position extremes at reset settings
	task automatic test_euler_directed();
		logic [31:0] deg [10];
		deg = '{32'h0, 32'h5A0000, 32'hB40000, 32'hFFA60000, 32'h10E0000,
			32'h1680000, 32'h2D0000, 32'h7FFFFFFF, 32'h80000000, 32'hFF4C0000};
		for (int i = 0; i < 10; i++)
			send_word(make_word(i[0] ? 32'h7FFFFFFF : 32'h80000000, deg[i],
				deg[(i + 3) % 10], deg[(i + 7) % 10], 32'h0));
	endtask

	// Quaternion extremes, including huge ones that saturate up and target
	task automatic test_quat_directed();
		write_reg(REG_MODE, 32'hFFFFFFFF);
		send_word(make_word(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		send_word(make_word(32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF));
		send_word(make_word(32'h80000000, 32'h0, 32'h0, 32'h0, 32'h80000000));
		send_word('{32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h0, 32'h0, 32'h0,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000});
		send_word('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0, 32'h0, 32'h10000});
		send_word('{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 32'h0,
			32'hB505, 32'h0, 32'h0, 32'hB505});
		// Only bit 0 of the mode register counts; unknown index is ignored
		write_reg(REG_MODE, 32'hFFFFFFFE);
		write_reg(REG_UNUSED, 32'hFFFFFFFF);
	endtask

	// Scale and offset extremes in Euler mode
	task automatic test_scale_offset();
		write_reg(REG_FACTOR_X, 32'h80000000);
		write_reg(REG_FACTOR_Y, 32'h7FFFFFFF);
		write_reg(REG_FACTOR_Z, 32'h0);
		write_reg(REG_OFFSET_X, 32'h7FFFFFFF);
		write_reg(REG_OFFSET_Y, 32'h80000000);
		write_reg(REG_OFFSET_Z, 32'h5A0000);
		for (int i = 0; i < 6; i++) send_word(rand_word());
	endtask

	// Random words over several register settings
	task automatic test_random_phases();
		logic [31:0] v;
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_MODE, 32'(ph[0]));
			for (int k = 0; k < 6; k++) begin
				v = (ph == 6) ? ((k < 3) ? 32'h10000 : 32'h0) : pick32(4 << FRAC);
				write_reg(REG_FACTOR_X + k[2:0], v);
			end
			quiet = (ph == 2);
			for (int i = 0; i < 90; i++) send_word(rand_word());
			quiet = 1'b0;
		end
	endtask

	// Hold the output off long enough to fill the pipeline and stall the input
	task automatic test_backpressure();
		write_reg(REG_MODE, 32'h0);
		hold_cycles = 300;
		quiet = 1'b1;
		for (int i = 0; i < 80; i++) send_word(rand_word());
		quiet = 1'b0;
	endtask

	// Receiver stall: random, or held for a counted stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 36);
		end
	end

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (basis_q.size() == 0) begin
				$display("%0t: unexpected word %h", $realtime, out_word);
				fail_cnt++;
			end else begin
				exp_w = basis_q.pop_front();
				if (out_word.eye_x !== exp_w.eye_x || out_word.eye_y !== exp_w.eye_y ||
					out_word.eye_z !== exp_w.eye_z) begin
					$display("%0t: eye expected %h %h %h actual %h %h %h", $realtime,
						exp_w.eye_x, exp_w.eye_y, exp_w.eye_z,
						out_word.eye_x, out_word.eye_y, out_word.eye_z);
					fail_cnt++;
				end
				if (out_word.target_x !== exp_w.target_x || out_word.target_y !== exp_w.target_y ||
					out_word.target_z !== exp_w.target_z) begin
					$display("%0t: target expected %h %h %h actual %h %h %h", $realtime,
						exp_w.target_x, exp_w.target_y, exp_w.target_z,
						out_word.target_x, out_word.target_y, out_word.target_z);
					fail_cnt++;
				end
				if (out_word.up_x !== exp_w.up_x || out_word.up_y !== exp_w.up_y ||
					out_word.up_z !== exp_w.up_z) begin
					$display("%0t: up expected %h %h %h actual %h %h %h", $realtime,
						exp_w.up_x, exp_w.up_y, exp_w.up_z,
						out_word.up_x, out_word.up_y, out_word.up_z);
					fail_cnt++;
				end
			end
		end
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
			65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
			16, 8, 4, 2};
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		cycle_cnt = 0;
		fail_cnt = 0;
		hold_cycles = 0;
		quiet = 1'b0;
		quat_mode = 1'b0;
		for (int k = 0; k < 3; k++) begin
			scale_q[k] = 32'sh10000;
			shift_q[k] = 32'sh0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_euler_directed();
		test_quat_directed();
		test_scale_offset();
		test_random_phases();
		test_backpressure();
		drain();
		if (fail_cnt == 0 && basis_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
